// File: hdl/ffaa_pkg.sv
// Shared types, codes and default sizes for the first-fit arena allocator.
// No dependencies; every other file refers to it by scoped names.
package ffaa_pkg;

  localparam int unsigned DEF_MAX_ARENA_BYTES = 65536;
  localparam int unsigned DEF_PAGE_BYTES      = 4096;
  localparam int unsigned DEF_HEADER_BYTES    = 32;
  localparam int unsigned DEF_MAX_CHUNKS      = 64;

  // fixed payload field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned REQ_W    = 32;
  localparam int unsigned OFF_W    = 17;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_DESTROY = 2'd1,
    FUNC_ALLOC   = 2'd2,
    FUNC_FREE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ARG = 2'd1,
    ST_UNINIT  = 2'd2,
    ST_NO_MEM  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_INIT,
    OP_DESTROY,
    OP_SCAN_START,
    OP_RD_I,
    OP_SCAN_NEXT,
    OP_ALLOC_HIT,
    OP_SH_RD,
    OP_SH_WR,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_FREE_HIT,
    OP_LO_DEC,
    OP_HI_INC,
    OP_SUM_START,
    OP_SUM_RD,
    OP_SUM_ACC,
    OP_WR_LO,
    OP_CMP_RD,
    OP_CMP_WR,
    OP_CMP_END,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e code;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  ready;
    logic  too_big;
    logic  too_small;
    logic  fit;
    logic  split;
    logic  scan_last;
    logic  match;
    logic  lo_stop;
    logic  hi_stop;
    logic  sum_last;
    logic  gone_zero;
    logic  cmp_done;
    logic  sh_done;
  } sts_t;

endpackage

// File: hdl/ffaa_in_if.sv
// Request channel interface: valid/ready plus the request fields.
// Depends on ffaa_pkg for field widths.
interface ffaa_in_if;
  logic                        valid;
  logic                        ready;
  logic [ffaa_pkg::FUNC_W-1:0] func;
  logic [ffaa_pkg::REQ_W-1:0]  request_bytes;
  logic [ffaa_pkg::OFF_W-1:0]  payload_offset;

  modport source (output valid, func, request_bytes, payload_offset, input ready);
  modport sink   (input valid, func, request_bytes, payload_offset, output ready);
endinterface

// File: hdl/ffaa_out_if.sv
// Result channel interface: valid/ready plus the result fields.
// Depends on ffaa_pkg for field widths.
interface ffaa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ffaa_pkg::STATUS_W-1:0] status;
  logic [ffaa_pkg::OFF_W-1:0]    result_offset;
  logic [ffaa_pkg::OFF_W-1:0]    arena_bytes;

  modport source (output valid, status, result_offset, arena_bytes, input ready);
  modport sink   (input valid, status, result_offset, arena_bytes, output ready);
endinterface

// File: hdl/ffaa_datapath.sv
// Datapath: chunk size memory, free marks, walk counters, page rounding.
// Executes one ffaa_pkg::op_e per cycle; depends on ffaa_pkg.
module ffaa_datapath #(
  parameter int unsigned MAX_ARENA_BYTES = ffaa_pkg::DEF_MAX_ARENA_BYTES,
  parameter int unsigned PAGE_BYTES      = ffaa_pkg::DEF_PAGE_BYTES,
  parameter int unsigned HEADER_BYTES    = ffaa_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_CHUNKS      = ffaa_pkg::DEF_MAX_CHUNKS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffaa_pkg::cmd_t                cmd_i,
  input  logic [ffaa_pkg::FUNC_W-1:0]   func_i,
  input  logic [ffaa_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [ffaa_pkg::OFF_W-1:0]    payload_offset_i,
  output ffaa_pkg::sts_t                sts_o,
  output logic [ffaa_pkg::STATUS_W-1:0] status_o,
  output logic [ffaa_pkg::OFF_W-1:0]    result_offset_o,
  output logic [ffaa_pkg::OFF_W-1:0]    arena_bytes_o
);

  localparam int unsigned AW = $clog2(MAX_ARENA_BYTES + PAGE_BYTES);
  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned PL = $clog2(PAGE_BYTES);
  localparam int unsigned SH = AW + PL;
  localparam int unsigned MW = AW + 2;
  localparam int unsigned PW = AW + MW;
  localparam int unsigned NW = 2 * AW;
  // ceil(2^SH / PAGE_BYTES): (v * RECIP) >> SH is v / PAGE_BYTES for every v below 2^AW
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

  ffaa_pkg::func_e func_q;
  logic [ffaa_pkg::REQ_W-1:0] req_q;
  logic [ffaa_pkg::OFF_W-1:0] poff_q;
  logic [AW-1:0] v_q, pages_q, total_q, base_q, sz_q, acc_q, off_q, rd_q;
  logic          ready_q;
  logic [CW-1:0] count_q, j_q, k_q;
  logic [IW-1:0] i_q, lo_q, hi_q;
  logic [MAX_CHUNKS-1:0] free_q;
  ffaa_pkg::status_e out_st_q;
  logic [AW-1:0] out_off_q, out_tot_q;

  logic [AW-1:0] mem [MAX_CHUNKS];

  logic [IW-1:0] gone, lo_m1, hi_p1, rd_addr, wr_addr;
  logic [CW-1:0] hi_nx;
  logic [AW-1:0] rounded, wr_data;
  logic [PW-1:0] prod;
  logic [NW-1:0] rnd_wide;
  logic          we;
  logic          fit, split;

  assign gone       = hi_q - lo_q;
  assign lo_m1      = lo_q - 1'b1;
  assign hi_p1      = hi_q + 1'b1;
  assign hi_nx      = CW'(hi_q) + 1'b1;
  // page count by reciprocal multiply, then back to bytes
  assign prod       = PW'(v_q) * PW'(RECIP);
  assign rnd_wide   = NW'(pages_q) * NW'(PAGE_BYTES);
  assign rounded    = rnd_wide[AW-1:0];
  assign fit        = free_q[i_q] && (33'(rd_q) >= 33'(req_q));
  assign split      = ((33'(rd_q) - 33'(req_q)) >= 33'(HEADER_BYTES)) &&
                      (count_q < CW'(MAX_CHUNKS));

  always_comb begin
    case (cmd_i.op)
      ffaa_pkg::OP_SH_RD:                      rd_addr = IW'(j_q - 1'b1);
      ffaa_pkg::OP_SUM_RD, ffaa_pkg::OP_CMP_RD: rd_addr = IW'(k_q);
      default:                                 rd_addr = i_q;
    endcase
  end

  always_comb begin
    we      = 1'b1;
    wr_addr = i_q;
    wr_data = rd_q;
    case (cmd_i.op)
      ffaa_pkg::OP_INIT: begin
        wr_addr = '0;
        wr_data = rounded - AW'(HEADER_BYTES);
      end
      ffaa_pkg::OP_SH_WR:  wr_addr = IW'(j_q);
      ffaa_pkg::OP_SPLIT1: begin
        wr_addr = i_q + 1'b1;
        wr_data = AW'(33'(sz_q) - 33'(req_q) - 33'(HEADER_BYTES));
      end
      ffaa_pkg::OP_SPLIT2: wr_data = AW'(req_q);
      ffaa_pkg::OP_WR_LO: begin
        wr_addr = lo_q;
        wr_data = acc_q;
      end
      ffaa_pkg::OP_CMP_WR: wr_addr = IW'(k_q - CW'(gone));
      default:             we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q    <= ffaa_pkg::FUNC_INIT;
      req_q     <= '0;
      poff_q    <= '0;
      v_q       <= '0;
      pages_q   <= '0;
      total_q   <= '0;
      ready_q   <= 1'b0;
      count_q   <= '0;
      free_q    <= '0;
      i_q       <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      j_q       <= '0;
      k_q       <= '0;
      base_q    <= '0;
      sz_q      <= '0;
      acc_q     <= '0;
      off_q     <= '0;
      out_st_q  <= ffaa_pkg::ST_OK;
      out_off_q <= '0;
      out_tot_q <= '0;
    end else begin
      case (cmd_i.op)
        ffaa_pkg::OP_LATCH: begin
          func_q <= ffaa_pkg::func_e'(func_i);
          req_q  <= request_bytes_i;
          poff_q <= payload_offset_i;
          off_q  <= '0;
        end
        ffaa_pkg::OP_DIV_START: begin
          v_q <= AW'(req_q) + AW'(PAGE_BYTES - 1);
        end
        ffaa_pkg::OP_DIV_STEP: begin
          pages_q <= AW'(prod >> SH);
        end
        ffaa_pkg::OP_INIT: begin
          total_q <= rounded;
          count_q <= CW'(1);
          ready_q <= 1'b1;
          free_q  <= MAX_CHUNKS'(1);
        end
        ffaa_pkg::OP_DESTROY: begin
          total_q <= '0;
          count_q <= '0;
          ready_q <= 1'b0;
          free_q  <= '0;
        end
        ffaa_pkg::OP_SCAN_START: begin
          i_q    <= '0;
          base_q <= '0;
        end
        ffaa_pkg::OP_SCAN_NEXT: begin
          base_q <= base_q + AW'(HEADER_BYTES) + rd_q;
          i_q    <= i_q + 1'b1;
        end
        ffaa_pkg::OP_ALLOC_HIT: begin
          off_q <= base_q + AW'(HEADER_BYTES);
          sz_q  <= rd_q;
          j_q   <= count_q;
          if (!split) begin
            free_q[i_q] <= 1'b0;
          end
        end
        ffaa_pkg::OP_SH_WR: begin
          free_q[IW'(j_q)] <= free_q[IW'(j_q - 1'b1)];
          j_q <= j_q - 1'b1;
        end
        ffaa_pkg::OP_SPLIT1: free_q[i_q + 1'b1] <= 1'b1;
        ffaa_pkg::OP_SPLIT2: begin
          free_q[i_q] <= 1'b0;
          count_q     <= count_q + 1'b1;
        end
        ffaa_pkg::OP_FREE_HIT: begin
          lo_q <= i_q;
          hi_q <= i_q;
        end
        ffaa_pkg::OP_LO_DEC: lo_q <= lo_m1;
        ffaa_pkg::OP_HI_INC: hi_q <= hi_p1;
        ffaa_pkg::OP_SUM_START: begin
          k_q   <= CW'(lo_q);
          acc_q <= '0;
        end
        ffaa_pkg::OP_SUM_ACC: begin
          // every merged chunk past the first gives back its header
          acc_q <= acc_q + rd_q + ((k_q != CW'(lo_q)) ? AW'(HEADER_BYTES) : '0);
          k_q   <= k_q + 1'b1;
        end
        ffaa_pkg::OP_WR_LO: begin
          free_q[lo_q] <= 1'b1;
          k_q          <= hi_nx;
        end
        ffaa_pkg::OP_CMP_WR: begin
          free_q[IW'(k_q - CW'(gone))] <= free_q[IW'(k_q)];
          k_q <= k_q + 1'b1;
        end
        ffaa_pkg::OP_CMP_END: count_q <= count_q - CW'(gone);
        ffaa_pkg::OP_RESULT: begin
          out_st_q  <= cmd_i.code;
          out_off_q <= off_q;
          out_tot_q <= total_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts_o.func      = func_q;
    sts_o.ready     = ready_q;
    sts_o.too_big   = 33'(req_q) > 33'(MAX_ARENA_BYTES);
    sts_o.too_small = rounded < AW'(HEADER_BYTES);
    sts_o.fit       = fit;
    sts_o.split     = split;
    sts_o.scan_last = (CW'(i_q) + 1'b1) >= count_q;
    sts_o.match     = (32'(base_q) + 32'(HEADER_BYTES)) == 32'(poff_q);
    sts_o.lo_stop   = (lo_q == '0) || !free_q[lo_m1];
    sts_o.hi_stop   = (hi_nx >= count_q) || !free_q[hi_p1];
    sts_o.sum_last  = (k_q == CW'(hi_q));
    sts_o.gone_zero = (hi_q == lo_q);
    sts_o.cmp_done  = (k_q >= count_q);
    sts_o.sh_done   = (j_q <= (CW'(i_q) + 1'b1));
  end

  assign status_o        = out_st_q;
  assign result_offset_o = ffaa_pkg::OFF_W'(out_off_q);
  assign arena_bytes_o   = ffaa_pkg::OFF_W'(out_tot_q);

endmodule

// File: hdl/ffaa_ctrl.sv
// Controller: sequences each request through the datapath operations.
// Depends on ffaa_pkg for commands and status flags.
module ffaa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ffaa_pkg::sts_t sts_i,
  output ffaa_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_DIV, S_CHK, S_SCAN_RD, S_SCAN_EV, S_SH, S_SH_WR,
    S_SPLIT1, S_SPLIT2, S_LO, S_HI, S_SUM_RD, S_SUM_ACC, S_WR_LO,
    S_CMP, S_CMP_WR, S_DONE
  } state_e;

  state_e            state_q, state_d;
  ffaa_pkg::status_e code_q, code_d;
  logic              out_valid_q, out_valid_d;
  logic              fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    cmd_o.op    = ffaa_pkg::OP_NONE;
    cmd_o.code  = code_q;
    fire        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ffaa_pkg::OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.func == ffaa_pkg::FUNC_INIT) begin
          if (sts_i.too_big) begin
            code_d  = ffaa_pkg::ST_BAD_ARG;
            state_d = S_DONE;
          end else begin
            cmd_o.op = ffaa_pkg::OP_DIV_START;
            state_d  = S_DIV;
          end
        end else if (!sts_i.ready) begin
          code_d  = ffaa_pkg::ST_UNINIT;
          state_d = S_DONE;
        end else if (sts_i.func == ffaa_pkg::FUNC_DESTROY) begin
          cmd_o.op = ffaa_pkg::OP_DESTROY;
          code_d   = ffaa_pkg::ST_OK;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = ffaa_pkg::OP_SCAN_START;
          state_d  = S_SCAN_RD;
        end
      end
      S_DIV: begin
        cmd_o.op = ffaa_pkg::OP_DIV_STEP;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (sts_i.too_small) begin
          code_d = ffaa_pkg::ST_BAD_ARG;
        end else begin
          cmd_o.op = ffaa_pkg::OP_INIT;
          code_d   = ffaa_pkg::ST_OK;
        end
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        cmd_o.op = ffaa_pkg::OP_RD_I;
        state_d  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (sts_i.func == ffaa_pkg::FUNC_ALLOC) begin
          if (sts_i.fit) begin
            cmd_o.op = ffaa_pkg::OP_ALLOC_HIT;
            code_d   = ffaa_pkg::ST_OK;
            state_d  = sts_i.split ? S_SH : S_DONE;
          end else begin
            cmd_o.op = ffaa_pkg::OP_SCAN_NEXT;
            if (sts_i.scan_last) begin
              code_d  = ffaa_pkg::ST_NO_MEM;
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end else begin
          if (sts_i.match) begin
            cmd_o.op = ffaa_pkg::OP_FREE_HIT;
            state_d  = S_LO;
          end else begin
            cmd_o.op = ffaa_pkg::OP_SCAN_NEXT;
            if (sts_i.scan_last) begin
              code_d  = ffaa_pkg::ST_BAD_ARG;
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end
      end
      S_SH: begin
        if (sts_i.sh_done) begin
          state_d = S_SPLIT1;
        end else begin
          cmd_o.op = ffaa_pkg::OP_SH_RD;
          state_d  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.op = ffaa_pkg::OP_SH_WR;
        state_d  = S_SH;
      end
      S_SPLIT1: begin
        cmd_o.op = ffaa_pkg::OP_SPLIT1;
        state_d  = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd_o.op = ffaa_pkg::OP_SPLIT2;
        state_d  = S_DONE;
      end
      S_LO: begin
        if (sts_i.lo_stop) state_d = S_HI;
        else               cmd_o.op = ffaa_pkg::OP_LO_DEC;
      end
      S_HI: begin
        if (sts_i.hi_stop) begin
          cmd_o.op = ffaa_pkg::OP_SUM_START;
          state_d  = S_SUM_RD;
        end else begin
          cmd_o.op = ffaa_pkg::OP_HI_INC;
        end
      end
      S_SUM_RD: begin
        cmd_o.op = ffaa_pkg::OP_SUM_RD;
        state_d  = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd_o.op = ffaa_pkg::OP_SUM_ACC;
        state_d  = sts_i.sum_last ? S_WR_LO : S_SUM_RD;
      end
      S_WR_LO: begin
        cmd_o.op = ffaa_pkg::OP_WR_LO;
        code_d   = ffaa_pkg::ST_OK;
        state_d  = sts_i.gone_zero ? S_DONE : S_CMP;
      end
      S_CMP: begin
        if (sts_i.cmp_done) begin
          cmd_o.op = ffaa_pkg::OP_CMP_END;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = ffaa_pkg::OP_CMP_RD;
          state_d  = S_CMP_WR;
        end
      end
      S_CMP_WR: begin
        cmd_o.op = ffaa_pkg::OP_CMP_WR;
        state_d  = S_CMP;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op   = ffaa_pkg::OP_RESULT;
          cmd_o.code = code_q;
          fire       = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fire)                           out_valid_d = 1'b1;
    else if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    else                                out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_q      <= ffaa_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: hdl/first_fit_arena_allocator.sv
// First-fit arena allocator with coalescing: controller plus datapath, one request at a time.
// Per request: destroy and an op on an uninitialized arena go straight to the result; init
// rounds the size up to whole pages; alloc scans chunks first-fit, and a split shifts the
// later chunks up; free scans for the matching offset and on a hit merges free neighbors,
// then moves the later chunks down. Next accept follows the result load.
// Reset is asynchronous: arena uninitialized, all free marks clear, no clearing pass.
module first_fit_arena_allocator #(
  parameter int unsigned MAX_ARENA_BYTES = ffaa_pkg::DEF_MAX_ARENA_BYTES,
  parameter int unsigned PAGE_BYTES      = ffaa_pkg::DEF_PAGE_BYTES,
  parameter int unsigned HEADER_BYTES    = ffaa_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_CHUNKS      = ffaa_pkg::DEF_MAX_CHUNKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffaa_in_if.sink     in_i,
  ffaa_out_if.source  out_o
);

  // command and status between the sequencer and the datapath
  ffaa_pkg::cmd_t cmd;
  ffaa_pkg::sts_t sts;

  // The controller takes a request only when idle; the result register
  // keeps the last transfer until the sink takes it, while a new request
  // is already being worked on. A result still waiting stalls the finish.
  ffaa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Chunk table: sizes in a memory with registered read, free marks in
  // flops so destroy clears them at once and init clears all but the first chunk's.
  ffaa_datapath #(
    .MAX_ARENA_BYTES (MAX_ARENA_BYTES),
    .PAGE_BYTES      (PAGE_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_CHUNKS      (MAX_CHUNKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .func_i           (in_i.func),
    .request_bytes_i  (in_i.request_bytes),
    .payload_offset_i (in_i.payload_offset),
    .sts_o            (sts),
    .status_o         (out_o.status),
    .result_offset_o  (out_o.result_offset),
    .arena_bytes_o    (out_o.arena_bytes)
  );

  // one request in flight: no second transfer right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while busy");

  // only a successful allocate reports a nonzero offset
  a_offset_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_offset != '0) |-> (out_o.status == ffaa_pkg::ST_OK))
    else $error("offset with failing status");

  // an uninitialized arena has zero size
  a_uninit_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ffaa_pkg::ST_UNINIT) |-> (out_o.arena_bytes == '0))
    else $error("uninitialized arena with nonzero size");

endmodule
